// ===== sv/lts_pkg.sv =====
// lts_pkg: shared codes, result record type and byte-class helpers for the
// Lisp token scanner. No dependencies.

package lts_pkg;

    // Scan mode codes
    localparam logic [2:0] MODE_IDLE          = 3'd0;
    localparam logic [2:0] MODE_SYMBOL        = 3'd1;
    localparam logic [2:0] MODE_STRING        = 3'd2;
    localparam logic [2:0] MODE_COMMENT       = 3'd3;
    localparam logic [2:0] MODE_HALT_UNMATCH  = 3'd4;
    localparam logic [2:0] MODE_HALT_LONG     = 3'd5;

    // Result kinds
    localparam logic [2:0] RK_BYTE            = 3'd0;
    localparam logic [2:0] RK_END             = 3'd1;
    localparam logic [2:0] RK_ERR_UNMATCH     = 3'd2;
    localparam logic [2:0] RK_ERR_LONG        = 3'd3;
    localparam logic [2:0] RK_EOT             = 3'd4;

    // Token kinds
    localparam logic [1:0] TK_SYMBOL          = 2'd0;
    localparam logic [1:0] TK_STRING          = 2'd1;
    localparam logic [1:0] TK_ONECHAR         = 2'd2;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_NUL             = 8'h00;
    localparam logic [7:0] CH_NEWLINE         = 8'h0A;
    localparam logic [7:0] CH_SPACE           = 8'h20;
    localparam logic [7:0] CH_DQUOTE          = 8'h22;
    localparam logic [7:0] CH_QUOTE           = 8'h27;
    localparam logic [7:0] CH_LPAREN          = 8'h28;
    localparam logic [7:0] CH_RPAREN          = 8'h29;
    localparam logic [7:0] CH_SEMI            = 8'h3B;
    localparam logic [7:0] CH_TAB             = 8'h09;
    localparam logic [7:0] CH_CR              = 8'h0D;

    // One result record
    typedef struct packed {
        logic [2:0] result_kind;
        logic [7:0] byte_out;
        logic [1:0] token_kind;
        logic       token_first;
        logic       last;
    } result_t;

    // Tab, newline, vertical tab, form feed, carriage return and space
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Bytes that close a symbol (not counting the length limit)
    function automatic logic is_sym_delim(input logic [7:0] c);
        return (c == CH_NUL) || is_blank(c) || (c == CH_LPAREN) || (c == CH_RPAREN);
    endfunction

endpackage

// ===== sv/lisp_token_scanner.sv =====
// lisp_token_scanner: streaming S-expression tokenizer, one text byte per request.
// Depends on lts_pkg (codes, result_t, byte-class functions).
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+----------------------------
//   char     | in        | char_valid / char_stall    | char_in
//   result   | out       | result_valid / result_stall| result_kind, byte_out,
//            |           |                            | token_kind, token_first, last
//
// A request is decoded in the cycle it is accepted: the mode and length registers
// update and its 0..3 results land in a 4-entry result queue at once. Results leave
// one per cycle while result_stall is low, so the rate is one byte per cycle for
// bytes that give at most one result; the queue's single read port sets the figure
// when a byte gives two or three. char_stall is high while the queue holds two or
// more results. Reset clears mode, length and queue; there is no clearing pass.

module lisp_token_scanner #(
    parameter int MAX_TOKEN = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_in,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [2:0] result_kind,
    output logic [7:0] byte_out,
    output logic [1:0] token_kind,
    output logic       token_first,
    output logic       last
);

    localparam int LEN_W = $clog2(MAX_TOKEN);
    localparam logic [LEN_W-1:0] LEN_LIM1 = LEN_W'(MAX_TOKEN - 1);
    localparam logic [LEN_W-1:0] LEN_LIM2 = LEN_W'(MAX_TOKEN - 2);

    logic [2:0]       mode_reg, mode_next;
    logic [LEN_W-1:0] len_reg, len_next;

    lts_pkg::result_t res [4];
    logic [1:0]       res_n;
    logic             do_idle;

    lts_pkg::result_t q_reg [4];
    logic [1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [2:0]       count_reg;

    logic accept;
    logic pop;

    assign char_stall   = (count_reg > 3'd1);
    assign accept       = char_valid && !char_stall;
    assign result_valid = (count_reg != 3'd0);
    assign pop          = result_valid && !result_stall;

    // Decode one byte against the current mode
    always_comb
    begin
        mode_next = mode_reg;
        len_next  = len_reg;
        res_n     = 2'd0;
        do_idle   = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            res[i] = '0;
        end

        unique case (mode_reg)
            lts_pkg::MODE_HALT_UNMATCH:
            begin
                res[0].result_kind = lts_pkg::RK_ERR_UNMATCH;
                res_n = 2'd1;
            end
            lts_pkg::MODE_HALT_LONG:
            begin
                res[0].result_kind = lts_pkg::RK_ERR_LONG;
                res_n = 2'd1;
            end
            lts_pkg::MODE_COMMENT:
            begin
                if (char_in == lts_pkg::CH_NUL)
                    do_idle = 1'b1;
                else if (char_in == lts_pkg::CH_NEWLINE)
                    mode_next = lts_pkg::MODE_IDLE;
            end
            lts_pkg::MODE_STRING:
            begin
                if (char_in == lts_pkg::CH_NUL)
                begin
                    mode_next = lts_pkg::MODE_HALT_UNMATCH;
                    res[0].result_kind = lts_pkg::RK_ERR_UNMATCH;
                    res_n = 2'd1;
                end
                else if (char_in == lts_pkg::CH_DQUOTE)
                begin
                    if (len_reg > LEN_LIM2)
                    begin
                        mode_next = lts_pkg::MODE_HALT_LONG;
                        res[0].result_kind = lts_pkg::RK_ERR_LONG;
                        res_n = 2'd1;
                    end
                    else
                    begin
                        res[0].result_kind = lts_pkg::RK_BYTE;
                        res[0].byte_out    = char_in;
                        res[0].token_kind  = lts_pkg::TK_STRING;
                        res[1].result_kind = lts_pkg::RK_END;
                        res[1].token_kind  = lts_pkg::TK_STRING;
                        res_n     = 2'd2;
                        mode_next = lts_pkg::MODE_IDLE;
                        len_next  = '0;
                    end
                end
                else if (len_reg <= LEN_LIM2)
                begin
                    res[0].result_kind = lts_pkg::RK_BYTE;
                    res[0].byte_out    = char_in;
                    res[0].token_kind  = lts_pkg::TK_STRING;
                    res_n    = 2'd1;
                    len_next = len_reg + LEN_W'(1);
                end
            end
            lts_pkg::MODE_SYMBOL:
            begin
                if (lts_pkg::is_sym_delim(char_in) || (len_reg >= LEN_LIM1))
                begin
                    res[0].result_kind = lts_pkg::RK_END;
                    res[0].token_kind  = lts_pkg::TK_SYMBOL;
                    res_n   = 2'd1;
                    do_idle = 1'b1;
                end
                else
                begin
                    res[0].result_kind = lts_pkg::RK_BYTE;
                    res[0].byte_out    = char_in;
                    res[0].token_kind  = lts_pkg::TK_SYMBOL;
                    res_n    = 2'd1;
                    len_next = len_reg + LEN_W'(1);
                end
            end
            default:
                do_idle = 1'b1;
        endcase

        // Byte handled as if between tokens; results follow any symbol end
        if (do_idle)
        begin
            mode_next = lts_pkg::MODE_IDLE;
            len_next  = '0;
            priority if (char_in == lts_pkg::CH_NUL)
            begin
                res[res_n].result_kind = lts_pkg::RK_EOT;
                res_n = res_n + 2'd1;
            end
            else if (lts_pkg::is_blank(char_in))
            begin
                mode_next = lts_pkg::MODE_IDLE;
            end
            else if (char_in == lts_pkg::CH_DQUOTE)
            begin
                mode_next = lts_pkg::MODE_STRING;
                len_next  = LEN_W'(1);
                res[res_n].result_kind = lts_pkg::RK_BYTE;
                res[res_n].byte_out    = char_in;
                res[res_n].token_kind  = lts_pkg::TK_STRING;
                res[res_n].token_first = 1'b1;
                res_n = res_n + 2'd1;
            end
            else if (char_in == lts_pkg::CH_SEMI)
            begin
                mode_next = lts_pkg::MODE_COMMENT;
            end
            else if ((char_in == lts_pkg::CH_LPAREN) || (char_in == lts_pkg::CH_RPAREN) ||
                     (char_in == lts_pkg::CH_QUOTE))
            begin
                res[res_n].result_kind       = lts_pkg::RK_BYTE;
                res[res_n].byte_out          = char_in;
                res[res_n].token_kind        = lts_pkg::TK_ONECHAR;
                res[res_n].token_first       = 1'b1;
                res[res_n + 2'd1].result_kind = lts_pkg::RK_END;
                res[res_n + 2'd1].token_kind  = lts_pkg::TK_ONECHAR;
                res_n = res_n + 2'd2;
            end
            else
            begin
                mode_next = lts_pkg::MODE_SYMBOL;
                len_next  = LEN_W'(1);
                res[res_n].result_kind = lts_pkg::RK_BYTE;
                res[res_n].byte_out    = char_in;
                res[res_n].token_kind  = lts_pkg::TK_SYMBOL;
                res[res_n].token_first = 1'b1;
                res_n = res_n + 2'd1;
            end
        end

        // Mark the final result of this byte
        for (int i = 0; i < 4; i++)
        begin
            res[i].last = (res_n != 2'd0) && (2'(i) == res_n - 2'd1);
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= lts_pkg::MODE_IDLE;
            len_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            len_reg  <= len_next;
        end
    end

    // Result queue: up to three writes per request, one read per cycle while not stalled
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (accept && ({1'b0, 2'(2'(i) - wr_ptr_reg)} < {1'b0, res_n}))
                q_reg[i] <= res[2'(2'(i) - wr_ptr_reg)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= wr_ptr_reg + res_n;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (accept ? {1'b0, res_n} : 3'd0) - (pop ? 3'd1 : 3'd0);
        end
    end

    assign result_kind = q_reg[rd_ptr_reg].result_kind;
    assign byte_out    = q_reg[rd_ptr_reg].byte_out;
    assign token_kind  = q_reg[rd_ptr_reg].token_kind;
    assign token_first = q_reg[rd_ptr_reg].token_first;
    assign last        = q_reg[rd_ptr_reg].last;

endmodule

// ===== sv/lts_checker.sv =====
// lts_checker: port-level checks on the token scanner's result stream, bound into
// lisp_token_scanner. Depends on lts_pkg for result and token kind codes.

module lts_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_stall,
    input logic [2:0] result_kind,
    input logic [7:0] byte_out,
    input logic [1:0] token_kind,
    input logic       token_first,
    input logic       last
);

    // A stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_kind) &&
        $stable(byte_out) && $stable(token_kind) && $stable(token_first) && $stable(last))
        else $error("stalled result changed");

    // Only token bytes carry data or a first mark
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind != lts_pkg::RK_BYTE) |-> (byte_out == 8'd0) && !token_first)
        else $error("non-byte result carries data");

    // Errors and end of text close the request and carry token kind code TK_SYMBOL (zero)
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result_kind == lts_pkg::RK_ERR_UNMATCH) ||
                         (result_kind == lts_pkg::RK_ERR_LONG) ||
                         (result_kind == lts_pkg::RK_EOT))
        |-> last && (token_kind == lts_pkg::TK_SYMBOL))
        else $error("bad error or end-of-text result");

    // A one-character token byte is marked first and is never the last result of its byte
    a_onechar: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == lts_pkg::RK_BYTE) &&
        (token_kind == lts_pkg::TK_ONECHAR) |-> !last && token_first)
        else $error("one-character token not closed");

endmodule

bind lisp_token_scanner lts_checker u_lts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .byte_out     (byte_out),
    .token_kind   (token_kind),
    .token_first  (token_first),
    .last         (last)
);
